// ----- hdl/tbd_pkg.sv -----
`timescale 1ns / 1ps

package tbd_pkg;

    // run table capacity and derived widths
    localparam int MAX_RUNS = 64;
    localparam int CNT_W    = $clog2(MAX_RUNS + 1);

    // field widths
    localparam int POS_W  = 32;
    localparam int ADDR_W = 30;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 1;

    // operation codes
    localparam logic [1:0] OP_LOAD_N    = 2'd0;
    localparam logic [1:0] OP_LOAD_MASK = 2'd1;
    localparam logic [1:0] OP_BYTE      = 2'd2;
    localparam logic [1:0] OP_CLEAR     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'd1;

    // characters
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_N = 8'h4E;
    localparam logic [7:0] LOWER_OFFSET = 8'h20;

    // one base travelling along the cell row
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
        logic [7:0]       letter;
        logic             n_hit;
        logic             m_hit;
        logic             last;
    } t_stage;

    // per-cell control from the top level
    typedef struct packed {
        logic advance;
        logic we_n;
        logic we_m;
        logic live_n;
        logic live_m;
    } t_cell_ctl;

    // 2-bit code to upper-case letter
    function automatic logic [7:0] base_letter(input logic [1:0] code);
        logic [7:0] ch;
        unique case (code)
            2'd0:    ch = CHAR_T;
            2'd1:    ch = CHAR_C;
            2'd2:    ch = CHAR_A;
            default: ch = CHAR_G;
        endcase
        return ch;
    endfunction

endpackage

// ----- hdl/tbd_in_if.sv -----
`timescale 1ns / 1ps

interface tbd_in_if;
    import tbd_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [POS_W-1:0]  run_start;
    logic [POS_W-1:0]  run_length;
    logic [7:0]        packed_byte;
    logic [ADDR_W-1:0] byte_address;

    modport source (
        output valid, operation, run_start, run_length, packed_byte, byte_address,
        input  ready
    );
    modport sink (
        input  valid, operation, run_start, run_length, packed_byte, byte_address,
        output ready
    );
endinterface

// ----- hdl/tbd_out_if.sv -----
`timescale 1ns / 1ps

interface tbd_out_if;
    import tbd_pkg::*;

    logic             valid;
    logic             ready;
    logic [7:0]       base_char;
    logic [POS_W-1:0] base_position;
    logic             last_of_item;

    modport source (
        output valid, base_char, base_position, last_of_item,
        input  ready
    );
    modport sink (
        input  valid, base_char, base_position, last_of_item,
        output ready
    );
endinterface

// ----- hdl/tbd_run_cell.sv -----
`timescale 1ns / 1ps

module tbd_run_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tbd_pkg::t_cell_ctl    i_ctl,
    input  logic [31:0]           i_wr_start,
    input  logic [31:0]           i_wr_len,
    input  tbd_pkg::t_stage       i_stage,
    output tbd_pkg::t_stage       o_stage
);
    import tbd_pkg::*;

    logic [POS_W-1:0] r_n_start;
    logic [POS_W-1:0] r_n_len;
    logic [POS_W-1:0] r_m_start;
    logic [POS_W-1:0] r_m_len;
    t_stage           r_stage;
    t_stage           n_stage;
    logic [POS_W-1:0] w_n_off;
    logic [POS_W-1:0] w_m_off;
    logic             w_n_cov;
    logic             w_m_cov;

    // half-open run check, the end never wraps
    assign w_n_off = i_stage.pos - r_n_start;
    assign w_m_off = i_stage.pos - r_m_start;
    assign w_n_cov = i_ctl.live_n && (i_stage.pos >= r_n_start) && (w_n_off < r_n_len);
    assign w_m_cov = i_ctl.live_m && (i_stage.pos >= r_m_start) && (w_m_off < r_m_len);

    always_comb begin
        n_stage       = i_stage;
        n_stage.n_hit = i_stage.n_hit | w_n_cov;
        n_stage.m_hit = i_stage.m_hit | w_m_cov;
    end

    // run entries held by this cell
    always_ff @(posedge i_clk) begin
        if (i_ctl.we_n) begin
            r_n_start <= i_wr_start;
            r_n_len   <= i_wr_len;
        end
        if (i_ctl.we_m) begin
            r_m_start <= i_wr_start;
            r_m_len   <= i_wr_len;
        end
    end

    // stage register towards the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ----- hdl/twobit_base_decoder.sv -----
`timescale 1ns / 1ps

// Decodes packed 2-bit DNA bytes into ASCII bases (T C A G, N inside unknown
// runs, lower case inside mask runs) for positions in [region_start,
// region_end). Each accepted item sits in a holding register; a packed byte
// then issues one base per cycle while the output does not stall, and the
// next item is taken once the holding register frees. Bases walk a row of
// MAX_RUNS cells, each holding one unknown run and one mask run, and pass
// from the issue register through the cell registers to the output register,
// one per cycle unless stalled. A load or clear item waits until no base is
// left in the issue register or the cell row and then updates the run tables.
// Output back-pressure stalls the whole row.
module twobit_base_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tbd_in_if.sink                          i_in,
    tbd_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [tbd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tbd_pkg::CFG_W-1:0]       i_cfg_data
);
    import tbd_pkg::*;

    logic [POS_W-1:0]  r_region_start;
    logic [POS_W-1:0]  r_region_end;

    logic              r_hold_valid;
    logic [1:0]        r_hold_op;
    logic [POS_W-1:0]  r_hold_start;
    logic [POS_W-1:0]  r_hold_len;
    logic [7:0]        r_hold_byte;
    logic [ADDR_W-1:0] r_hold_addr;
    logic [1:0]        r_k;

    logic [CNT_W-1:0]  r_n_count;
    logic [CNT_W-1:0]  r_m_count;

    t_stage            r_iss;
    t_stage            n_iss;

    logic              r_out_valid;
    logic [7:0]        r_out_char;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_last;

    logic              w_advance;
    logic              w_busy;
    logic              w_ctl_go;
    logic              w_byte_go;
    logic [3:0]        w_emit;
    logic [3:0]        w_later;
    logic [1:0]        w_code;
    logic [POS_W-1:0]  w_pos;
    logic [7:0]        w_char;
    logic [MAX_RUNS:0] w_valids;

    t_stage            w_stage [MAX_RUNS+1];
    t_cell_ctl         w_ctl   [MAX_RUNS];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_start <= '0;
            r_region_end   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REGION_START: r_region_start <= i_cfg_data;
                CFG_REGION_END:   r_region_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole row stalls while a result waits at the output
    assign w_advance = !r_out_valid || o_out.ready;

    // any base still travelling the cell row
    always_comb begin
        for (int i = 0; i <= MAX_RUNS; i++) begin
            w_valids[i] = w_stage[i].valid;
        end
    end
    assign w_busy = |w_valids;

    assign w_byte_go = r_hold_valid && (r_hold_op == OP_BYTE) && w_advance;
    assign w_ctl_go  = r_hold_valid && (r_hold_op != OP_BYTE) && !w_busy;

    // region check for the four bases of the held byte
    always_comb begin
        logic [POS_W-1:0] pos_k;
        for (int k = 0; k < 4; k++) begin
            pos_k     = {r_hold_addr, 2'(k)};
            w_emit[k] = (pos_k >= r_region_start) && (pos_k < r_region_end);
        end
        for (int k = 0; k < 4; k++) begin
            w_later[k] = 1'b0;
            for (int j = k + 1; j < 4; j++) begin
                w_later[k] = w_later[k] | w_emit[j];
            end
        end
    end

    // base issue, first base in the top bits
    assign w_code = 2'((r_hold_byte >> {~r_k, 1'b0}) & 8'h03);
    assign w_pos  = {r_hold_addr, r_k};

    always_comb begin
        n_iss        = '0;
        n_iss.valid  = w_byte_go && w_emit[r_k];
        n_iss.pos    = w_pos;
        n_iss.letter = base_letter(w_code);
        n_iss.last   = !w_later[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss.valid <= 1'b0;
        end else if (w_advance) begin
            r_iss <= n_iss;
        end
    end

    // holding register and base counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_k          <= 2'd0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_hold_valid <= 1'b1;
            end else if (w_ctl_go || (w_byte_go && (r_k == 2'd3))) begin
                r_hold_valid <= 1'b0;
            end
            if (w_byte_go) begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_hold_op    <= i_in.operation;
            r_hold_start <= i_in.run_start;
            r_hold_len   <= i_in.run_length;
            r_hold_byte  <= i_in.packed_byte;
            r_hold_addr  <= i_in.byte_address;
        end
    end

    assign i_in.ready = !r_hold_valid;

    // run counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_count <= '0;
            r_m_count <= '0;
        end else if (w_ctl_go) begin
            unique case (r_hold_op)
                OP_LOAD_N: begin
                    if (r_n_count < CNT_W'(MAX_RUNS)) begin
                        r_n_count <= r_n_count + CNT_W'(1);
                    end
                end
                OP_LOAD_MASK: begin
                    if (r_m_count < CNT_W'(MAX_RUNS)) begin
                        r_m_count <= r_m_count + CNT_W'(1);
                    end
                end
                OP_CLEAR: begin
                    r_n_count <= '0;
                    r_m_count <= '0;
                end
                default: ;
            endcase
        end
    end

    // per-cell write enables and live flags
    always_comb begin
        for (int i = 0; i < MAX_RUNS; i++) begin
            w_ctl[i].advance = w_advance;
            w_ctl[i].we_n    = w_ctl_go && (r_hold_op == OP_LOAD_N)
                               && (r_n_count == CNT_W'(i));
            w_ctl[i].we_m    = w_ctl_go && (r_hold_op == OP_LOAD_MASK)
                               && (r_m_count == CNT_W'(i));
            w_ctl[i].live_n  = CNT_W'(i) < r_n_count;
            w_ctl[i].live_m  = CNT_W'(i) < r_m_count;
        end
    end

    // row of run cells
    assign w_stage[0] = r_iss;

    for (genvar g = 0; g < MAX_RUNS; g++) begin : g_cell
        tbd_run_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[g]),
            .i_wr_start (r_hold_start),
            .i_wr_len   (r_hold_len),
            .i_stage    (w_stage[g]),
            .o_stage    (w_stage[g+1])
        );
    end

    // final character: unknown first, then lower case
    always_comb begin
        w_char = w_stage[MAX_RUNS].n_hit ? CHAR_N : w_stage[MAX_RUNS].letter;
        if (w_stage[MAX_RUNS].m_hit) begin
            w_char = 8'(w_char + LOWER_OFFSET);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_stage[MAX_RUNS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_char <= w_char;
            r_out_pos  <= w_stage[MAX_RUNS].pos;
            r_out_last <= w_stage[MAX_RUNS].last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.base_char     = r_out_char;
    assign o_out.base_position = r_out_pos;
    assign o_out.last_of_item  = r_out_last;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_n_count <= CNT_W'(MAX_RUNS)) && (r_m_count <= CNT_W'(MAX_RUNS)))
        else $error("run count beyond table capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl_go && (r_hold_op == OP_CLEAR)) |=> (r_n_count == '0) && (r_m_count == '0))
        else $error("clear item left runs in the tables");

    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_hold_valid)
        else $error("accepted item not held");

    a_issue_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_iss.valid && !$past(!i_rst_n) && $past(w_advance)) |-> $past(r_hold_valid))
        else $error("base issued with no item held");

endmodule
